FILE: sv/cit_pkg.sv
// Shared types, constants and helper functions for the CAN identifier tracker.
// Used by cit_cell and can_id_tracker_autobaud; depends on nothing else.
`default_nettype none

package cit_pkg;

   // Table size and number of selectable bus rates.
   localparam int TABLE_ENTRIES = 12;
   localparam int RATE_COUNT    = 4;

   // Width that holds a slot index or an occupancy count up to TABLE_ENTRIES.
   localparam int IDX_W = $clog2(TABLE_ENTRIES + 1);

   localparam int ID_W    = 29;
   localparam int HITS_W  = 32;
   localparam int RATE_W  = 2;
   localparam int LISTEN_W = 16;

   localparam logic [LISTEN_W-1:0] LISTEN_RESET = 16'd1500;

   // Command codes carried with each request.
   localparam logic [2:0] CMD_FRAME   = 3'd0;
   localparam logic [2:0] CMD_TICK    = 3'd1;
   localparam logic [2:0] CMD_RESTART = 3'd2;
   localparam logic [2:0] CMD_NEXT    = 3'd3;
   localparam logic [2:0] CMD_PAUSE   = 3'd4;

   // Protocol guess codes.
   localparam logic [1:0] PROTO_RAW      = 2'd0;
   localparam logic [1:0] PROTO_CANOPEN  = 2'd1;
   localparam logic [1:0] PROTO_EXTENDED = 2'd2;
   localparam logic [1:0] PROTO_J1939    = 2'd3;

   localparam logic [ID_W-1:0] J1939_LOW   = 29'h18f00000;
   localparam logic [ID_W-1:0] J1939_HIGH  = 29'h1cffffff;
   localparam logic [ID_W-1:0] COPEN_ZERO  = 29'h000;
   localparam logic [ID_W-1:0] COPEN_A_LO  = 29'h080;
   localparam logic [ID_W-1:0] COPEN_A_HI  = 29'h5ff;
   localparam logic [ID_W-1:0] COPEN_B_LO  = 29'h700;
   localparam logic [ID_W-1:0] COPEN_B_HI  = 29'h77f;

   localparam logic [HITS_W-1:0] HITS_MAX = '1;

   // Lookup request that walks down the row of table cells.
   typedef struct packed {
      logic              valid;
      logic [ID_W-1:0]   ident;
      logic              ext;
      logic              done;
      logic              alloc;
      logic [IDX_W-1:0]  slot;
      logic [HITS_W-1:0] count;
   } probe_type;

   // Next protocol guess after a frame with this identifier.
   function automatic logic [1:0] classify(input logic [ID_W-1:0] ident,
                                           input logic ext,
                                           input logic [1:0] proto);
      logic [1:0] res;
      res = proto;
      if (ext) begin
         if (ident >= J1939_LOW && ident <= J1939_HIGH) begin
            res = PROTO_J1939;
         end else if (proto == PROTO_RAW) begin
            res = PROTO_EXTENDED;
         end
      end else if (ident == COPEN_ZERO ||
                   (ident >= COPEN_A_LO && ident <= COPEN_A_HI) ||
                   (ident >= COPEN_B_LO && ident <= COPEN_B_HI)) begin
         res = PROTO_CANOPEN;
      end
      return res;
   endfunction

   // Step to the next rate index, wrapping at RATE_COUNT.
   function automatic logic [RATE_W-1:0] next_rate(input logic [RATE_W-1:0] rate);
      logic [RATE_W-1:0] res;
      if (rate == RATE_W'(RATE_COUNT - 1)) begin
         res = '0;
      end else begin
         res = rate + 1'b1;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: sv/cit_cell.sv
// One identifier table cell: holds one entry and checks the passing lookup.
// Depends on cit_pkg for the probe type and widths.
`default_nettype none

module cit_cell
   import cit_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             clear,
   input  wire logic [IDX_W-1:0] cell_index,
   input  wire probe_type        probe_in,
   output probe_type             probe_out
);

   logic [ID_W-1:0]   ident_ff;
   logic              ext_ff;
   logic [HITS_W-1:0] hits_ff, hits_in;
   logic              pvalid_ff;
   probe_type         probe_ff, probe_in_d;

   logic              occupied;
   logic              active;
   logic              hit;
   logic              alloc;
   logic [HITS_W-1:0] hits_inc;

   // Occupied entries always form a prefix of the row, so the first empty
   // cell a pending lookup meets is where a new identifier belongs.
   assign occupied = (hits_ff != '0);
   assign active   = probe_in.valid && !probe_in.done;
   assign hit      = active && occupied && (ident_ff == probe_in.ident) &&
                     (ext_ff == probe_in.ext);
   assign alloc    = active && !occupied;
   assign hits_inc = (hits_ff == HITS_MAX) ? hits_ff : hits_ff + 1'b1;

   // Next hit count: clear, saturating bump, or fresh entry.
   always_comb begin
      hits_in = hits_ff;
      if (clear) begin
         hits_in = '0;
      end else if (hit) begin
         hits_in = hits_inc;
      end else if (alloc) begin
         hits_in = HITS_W'(1);
      end
   end

   // Lookup handed on to the next cell.
   always_comb begin
      probe_in_d = probe_in;
      if (hit) begin
         probe_in_d.done  = 1'b1;
         probe_in_d.slot  = cell_index;
         probe_in_d.count = hits_inc;
      end else if (alloc) begin
         probe_in_d.done  = 1'b1;
         probe_in_d.alloc = 1'b1;
         probe_in_d.slot  = cell_index;
         probe_in_d.count = HITS_W'(1);
      end
   end

   // Hit count and probe valid are control state; identifier is payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         hits_ff   <= '0;
         pvalid_ff <= 1'b0;
      end else begin
         hits_ff   <= hits_in;
         pvalid_ff <= probe_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (clear) begin
         ident_ff <= '0;
         ext_ff   <= 1'b0;
      end else if (alloc) begin
         ident_ff <= probe_in.ident;
         ext_ff   <= probe_in.ext;
      end
      probe_ff <= probe_in_d;
   end

   always_comb begin
      probe_out       = probe_ff;
      probe_out.valid = pvalid_ff;
   end

endmodule

`default_nettype wire

FILE: sv/can_id_tracker_autobaud.sv
// Top level of the passive CAN monitor: command decode, auto-baud control
// and a row of cit_cell table cells. Depends on cit_pkg and cit_cell.
`default_nettype none

//  Channel   Direction  Ports                       Contents
//  req_      in         tvalid/tready/tdata/tuser   one command request
//  rsp_      out        tvalid/tready/tdata         one status result per request
//  csr_      in         we/wdata                    listen_ticks register
//
// An unpaused frame request walks the row of TABLE_ENTRIES cells one cell per
// cycle; once it leaves the last cell, ST_SCAN registers its outcome and ST_EMIT
// registers the result, and the next request is taken back in ST_IDLE. Any other
// request goes from ST_IDLE straight to ST_EMIT. A new request is accepted while
// the previous result waits on rsp_tready; a second pending result stalls req_.
// Synchronous active-high reset empties the table and restores the control state.

module can_id_tracker_autobaud
   import cit_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // Request: tdata [28:0] frame_id, [29] frame_extended, [31:30] zero.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,
   // Request: tuser [2:0] command.
   input  wire logic [2:0]  req_tuser,
   // Result: tdata [1:0] baud_index, [2] auto_mode, [3] paused_flag,
   // [4] reconfigure, [6:5] protocol_guess, [38:7] frames_seen,
   // [42:39] matched_slot, [74:43] slot_count, [75] table_full_drop,
   // [79:76] distinct_ids.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [79:0]      rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata
);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EMIT} state_type;

   state_type           state_ff, state_in;
   logic [LISTEN_W-1:0] listen_ticks_ff;
   logic [HITS_W-1:0]   total_ff, total_in;
   logic [1:0]          proto_ff, proto_in;
   logic [RATE_W-1:0]   rate_ff, rate_in;
   logic                auto_ff, auto_in;
   logic                pause_ff, pause_in;
   logic [LISTEN_W-1:0] elapsed_ff, elapsed_in;
   logic [IDX_W-1:0]    distinct_ff, distinct_in;
   logic                reconf_ff, reconf_in;
   logic [IDX_W-1:0]    slot_ff, slot_in;
   logic [HITS_W-1:0]   count_ff, count_in;
   logic                drop_ff, drop_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [79:0]         rsp_data_ff, rsp_data_in;

   logic                accept;
   logic                clear;
   logic [2:0]          cmd;
   logic [ID_W-1:0]     req_ident;
   logic                req_ext;
   logic                out_free;
   logic [LISTEN_W-1:0] elapsed_inc;
   probe_type           probe [TABLE_ENTRIES+1];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign cmd        = req_tuser;
   assign req_ident  = req_tdata[ID_W-1:0];
   assign req_ext    = req_tdata[ID_W];
   assign clear      = accept && (cmd == CMD_RESTART || cmd == CMD_NEXT);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;

   // The lookup enters the row on an accepted, unpaused frame.
   always_comb begin
      probe[0]       = '0;
      probe[0].valid = accept && (cmd == CMD_FRAME) && !pause_ff;
      probe[0].ident = req_ident;
      probe[0].ext   = req_ext;
   end

   // Row of table cells.
   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      cit_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .clear      (clear),
         .cell_index (IDX_W'(g)),
         .probe_in   (probe[g]),
         .probe_out  (probe[g+1])
      );
   end

   // Command decode, auto-baud control and result assembly.
   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      proto_in     = proto_ff;
      rate_in      = rate_ff;
      auto_in      = auto_ff;
      pause_in     = pause_ff;
      elapsed_in   = elapsed_ff;
      distinct_in  = distinct_ff;
      reconf_in    = reconf_ff;
      slot_in      = slot_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               reconf_in = 1'b0;
               slot_in   = IDX_W'(TABLE_ENTRIES);
               count_in  = '0;
               drop_in   = 1'b0;
               state_in  = ST_EMIT;
               case (cmd)
                  CMD_FRAME: begin
                     if (!pause_ff) begin
                        total_in = (total_ff == HITS_MAX) ? total_ff : total_ff + 1'b1;
                        proto_in = classify(req_ident, req_ext, proto_ff);
                        state_in = ST_SCAN;
                     end
                  end
                  CMD_TICK: begin
                     if (auto_ff && total_ff == '0) begin
                        if (elapsed_inc >= listen_ticks_ff) begin
                           rate_in    = next_rate(rate_ff);
                           elapsed_in = '0;
                           reconf_in  = 1'b1;
                        end else begin
                           elapsed_in = elapsed_inc;
                        end
                     end else if (auto_ff) begin
                        auto_in = 1'b0;
                     end
                  end
                  CMD_RESTART: begin
                     auto_in     = 1'b1;
                     pause_in    = 1'b0;
                     rate_in     = '0;
                     total_in    = '0;
                     proto_in    = PROTO_RAW;
                     distinct_in = '0;
                     elapsed_in  = '0;
                     reconf_in   = 1'b1;
                  end
                  CMD_NEXT: begin
                     auto_in     = 1'b0;
                     pause_in    = 1'b0;
                     rate_in     = next_rate(rate_ff);
                     total_in    = '0;
                     proto_in    = PROTO_RAW;
                     distinct_in = '0;
                     elapsed_in  = '0;
                     reconf_in   = 1'b1;
                  end
                  CMD_PAUSE: begin
                     pause_in = !pause_ff;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // The lookup leaves the last cell with its outcome.
            if (probe[TABLE_ENTRIES].valid) begin
               if (probe[TABLE_ENTRIES].done) begin
                  slot_in  = probe[TABLE_ENTRIES].slot;
                  count_in = probe[TABLE_ENTRIES].count;
               end else begin
                  drop_in = 1'b1;
               end
               if (probe[TABLE_ENTRIES].alloc) begin
                  distinct_in = distinct_ff + 1'b1;
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'(distinct_ff), drop_ff, count_ff, 4'(slot_ff),
                               total_ff, proto_ff, reconf_ff, pause_ff, auto_ff,
                               rate_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         listen_ticks_ff <= LISTEN_RESET;
         total_ff        <= '0;
         proto_ff        <= PROTO_RAW;
         rate_ff         <= '0;
         auto_ff         <= 1'b1;
         pause_ff        <= 1'b0;
         elapsed_ff      <= '0;
         distinct_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         proto_ff     <= proto_in;
         rate_ff      <= rate_in;
         auto_ff      <= auto_in;
         pause_ff     <= pause_in;
         elapsed_ff   <= elapsed_in;
         distinct_ff  <= distinct_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            listen_ticks_ff <= csr_wdata;
         end
      end
   end

   // Per-request result payload.
   always_ff @(posedge clock) begin
      reconf_ff   <= reconf_in;
      slot_ff     <= slot_in;
      count_ff    <= count_in;
      drop_ff     <= drop_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: test/tb_can_id_tracker_autobaud.sv
// Self-checking testbench for can_id_tracker_autobaud: directed script, then
// random command traffic checked against a behavioral tracker model.
// Depends on cit_pkg and the can_id_tracker_autobaud RTL.
`timescale 1ns / 1ps

module tb_can_id_tracker_autobaud;
   import cit_pkg::*;

   // Commands that the block ignores.
   localparam logic [2:0] CMD_SPARE_LO = 3'd5;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;

   localparam logic [3:0] NO_SLOT   = 4'(TABLE_ENTRIES);
   localparam int         DRAIN_CYC = TABLE_ENTRIES + 8;
   localparam int         HOLD_CYC  = 400;
   localparam int         PHASES    = 7;
   localparam int         PHASE_REQ = 112;

   // Result layout, highest field first so that it matches rsp_tdata.
   typedef struct packed {
      logic [3:0]  distinct_ids;
      logic        full_drop;
      logic [31:0] slot_count;
      logic [3:0]  matched_slot;
      logic [31:0] frames_seen;
      logic [1:0]  proto;
      logic        reconfigure;
      logic        paused;
      logic        auto_mode;
      logic [1:0]  baud;
   } status_type;

   typedef struct {
      logic [2:0]  cmd;
      logic [28:0] id;
      logic        ext;
      bit          typed;
      status_type  want;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [2:0]  req_tuser = CMD_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = '0;

   // Tracker model state.
   logic [15:0] listen_limit;
   logic [28:0] id_q [TABLE_ENTRIES];
   logic        ext_q [TABLE_ENTRIES];
   logic [31:0] hits_q [TABLE_ENTRIES];
   logic [31:0] frame_total;
   logic [1:0]  proto_q;
   logic [1:0]  rate_q;
   logic        auto_q;
   logic        paused_q;
   logic [15:0] listen_q;

   status_type  status_queue[$];
   int unsigned error_count = 0;

   // Traffic shaping.
   logic [29:0] id_pool [16];
   logic [29:0] edge_ids [16];
   bit          send_calm = 1'b0;
   int unsigned send_count = 0;
   bit          recv_calm = 1'b0;
   int unsigned recv_cycles = 0;
   int unsigned stall_left = 0;
   int unsigned stall_pick;
   bit          hold_off_request = 1'b0;

   can_id_tracker_autobaud dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // 50 MHz clock.
   initial begin
      forever #10 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic status_type make_status(input int baud, input int auto_mode,
                                              input int paused, input int reconf,
                                              input logic [1:0] proto, input int frames,
                                              input int slot, input int count,
                                              input int drop, input int ids);
      status_type s;
      s.baud         = 2'(baud);
      s.auto_mode    = 1'(auto_mode);
      s.paused       = 1'(paused);
      s.reconfigure  = 1'(reconf);
      s.proto        = proto;
      s.frames_seen  = 32'(frames);
      s.matched_slot = 4'(slot);
      s.slot_count   = 32'(count);
      s.full_drop    = 1'(drop);
      s.distinct_ids = 4'(ids);
      return s;
   endfunction

   // Protocol guess after one frame.
   function automatic logic [1:0] next_guess(input logic [1:0] guess, input logic [28:0] id,
                                             input logic ext);
      bit canopen;
      canopen = (id == COPEN_ZERO) || (id >= COPEN_A_LO && id <= COPEN_A_HI) ||
                (id >= COPEN_B_LO && id <= COPEN_B_HI);
      if (ext && id >= J1939_LOW && id <= J1939_HIGH) return PROTO_J1939;
      if (ext && guess == PROTO_RAW) return PROTO_EXTENDED;
      if (!ext && canopen) return PROTO_CANOPEN;
      return guess;
   endfunction

   function automatic void clear_capture();
      int i;
      for (i = 0; i < TABLE_ENTRIES; i++) begin
         id_q[i]   = '0;
         ext_q[i]  = 1'b0;
         hits_q[i] = '0;
      end
      frame_total = '0;
      proto_q     = PROTO_RAW;
   endfunction

   // Applies one request to the tracker model and returns the status it gives.
   function automatic status_type track_request(input logic [2:0] cmd,
                                                input logic [28:0] id,
                                                input logic ext);
      status_type s;
      int         hit;
      int         i;
      int         used;
      s = '0;
      s.matched_slot = NO_SLOT;
      case (cmd)
         CMD_FRAME: begin
            if (!paused_q) begin
               if (frame_total != HITS_MAX) frame_total++;
               proto_q = next_guess(proto_q, id, ext);
               hit = -1;
               for (i = 0; i < TABLE_ENTRIES; i++) begin
                  if (hit < 0 && hits_q[i] != 0 && id_q[i] == id && ext_q[i] == ext) hit = i;
               end
               if (hit >= 0) begin
                  if (hits_q[hit] != HITS_MAX) hits_q[hit]++;
               end else begin
                  // First empty entry takes the new identifier.
                  for (i = 0; i < TABLE_ENTRIES; i++) begin
                     if (hit < 0 && hits_q[i] == 0) begin
                        hit       = i;
                        id_q[i]   = id;
                        ext_q[i]  = ext;
                        hits_q[i] = 32'd1;
                     end
                  end
                  if (hit < 0) s.full_drop = 1'b1;
               end
               if (hit >= 0) begin
                  s.matched_slot = 4'(hit);
                  s.slot_count   = hits_q[hit];
               end
            end
         end
         CMD_TICK: begin
            if (auto_q && frame_total == 0) begin
               if (listen_q != 16'hFFFF) listen_q++;
               if (listen_q >= listen_limit) begin
                  rate_q        = 2'((int'(rate_q) + 1) % RATE_COUNT);
                  listen_q      = '0;
                  s.reconfigure = 1'b1;
               end
            end else if (auto_q) begin
               // Traffic was heard at this rate, so the search stops here.
               auto_q = 1'b0;
            end
         end
         CMD_RESTART, CMD_NEXT: begin
            if (cmd == CMD_RESTART) rate_q = '0;
            else rate_q = 2'((int'(rate_q) + 1) % RATE_COUNT);
            auto_q        = (cmd == CMD_RESTART);
            paused_q      = 1'b0;
            listen_q      = '0;
            s.reconfigure = 1'b1;
            clear_capture();
         end
         CMD_PAUSE: paused_q = ~paused_q;
         default: ;
      endcase
      used = 0;
      for (i = 0; i < TABLE_ENTRIES; i++) begin
         if (hits_q[i] != 0) used++;
      end
      s.baud         = rate_q;
      s.auto_mode    = auto_q;
      s.paused       = paused_q;
      s.proto        = proto_q;
      s.frames_seen  = frame_total;
      s.distinct_ids = 4'(used);
      return s;
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s expected 0x%0h actual 0x%0h", $realtime, name, want, got);
      end
   endfunction

   function automatic void check_status(input status_type got);
      status_type want;
      if (status_queue.size() == 0) begin
         error_count++;
         $display("%0t: status expected none actual 0x%h", $realtime, got);
         return;
      end
      want = status_queue.pop_front();
      compare_field("baud_index", 32'(want.baud), 32'(got.baud));
      compare_field("auto_mode", 32'(want.auto_mode), 32'(got.auto_mode));
      compare_field("paused_flag", 32'(want.paused), 32'(got.paused));
      compare_field("reconfigure", 32'(want.reconfigure), 32'(got.reconfigure));
      compare_field("protocol_guess", 32'(want.proto), 32'(got.proto));
      compare_field("frames_seen", want.frames_seen, got.frames_seen);
      compare_field("matched_slot", 32'(want.matched_slot), 32'(got.matched_slot));
      compare_field("slot_count", want.slot_count, got.slot_count);
      compare_field("table_full_drop", 32'(want.full_drop), 32'(got.full_drop));
      compare_field("distinct_ids", 32'(want.distinct_ids), 32'(got.distinct_ids));
   endfunction

   // Result side: checks every accepted status and stalls at random.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_status(status_type'(rsp_tdata));
      recv_cycles++;
      if (recv_cycles % 256 == 0) recv_calm = ($urandom_range(3) == 0);
      if (hold_off_request) begin
         hold_off_request = 1'b0;
         stall_left       = HOLD_CYC;
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!recv_calm) begin
            stall_pick = $urandom_range(99);
            if (stall_pick < 25) stall_left = $urandom_range(1, 3);
            else if (stall_pick < 27) stall_left = $urandom_range(20, 60);
         end
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned k;
      if (send_calm) return 0;
      k = $urandom_range(99);
      if (k < 60) return 0;
      if (k < 90) return $urandom_range(1, 3);
      if (k < 97) return $urandom_range(4, 8);
      return $urandom_range(20, 60);
   endfunction

   // Offers one request, waits for the handshake, then records its status.
   task automatic send_request(input logic [2:0] cmd, input logic [28:0] id, input logic ext,
                               input bit typed, input status_type want);
      status_type  predicted;
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b00, ext, id};
      do @(posedge clock); while (!req_tready);
      predicted = track_request(cmd, id, ext);
      status_queue.push_back(typed ? want : predicted);
      send_count++;
      if (send_count % 50 == 0) send_calm = ($urandom_range(3) == 0);
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops offering and waits until every status has come back.
   task automatic drain_status();
      req_tvalid <= 1'b0;
      while (status_queue.size() != 0) @(posedge clock);
   endtask

   task automatic write_listen(input logic [15:0] value);
      drain_status();
      repeat (DRAIN_CYC) @(posedge clock);
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we       <= 1'b0;
      listen_limit  = value;
   endtask

   task automatic pick_frame(output logic [28:0] id, output logic ext);
      logic [29:0] entry;
      if ($urandom_range(9) < 8) begin
         entry = id_pool[$urandom_range(15)];
         ext   = entry[29];
         id    = entry[28:0];
      end else begin
         ext = 1'($urandom);
         id  = 29'($urandom);
         if (!ext && $urandom_range(1) == 0) id = id & 29'h7ff;
      end
   endtask

   // Fresh identifier mix: classifier boundaries and random values.
   task automatic refill_pool();
      int i;
      for (i = 0; i < 16; i++) begin
         if ($urandom_range(1) == 0) id_pool[i] = edge_ids[$urandom_range(15)];
         else if ($urandom_range(1) == 0) id_pool[i] = {1'b1, 29'($urandom)};
         else id_pool[i] = {1'b0, 18'd0, 11'($urandom)};
      end
   endtask

   // Random traffic in short, meaningful bursts.
   task automatic run_traffic(input int unsigned quota);
      int unsigned counted;
      int unsigned pick;
      int unsigned n;
      logic [28:0] id;
      logic        ext;
      counted = 0;
      while (counted < quota) begin
         pick = $urandom_range(99);
         if (pick < 50) begin
            n = $urandom_range(1, 10);
            repeat (n) begin
               pick_frame(id, ext);
               send_request(CMD_FRAME, id, ext, 1'b0, '0);
            end
            counted += n;
         end else if (pick < 74) begin
            n = $urandom_range(1, 6);
            repeat (n) send_request(CMD_TICK, 29'($urandom), 1'($urandom), 1'b0, '0);
            counted += n;
         end else if (pick < 83) begin
            // Restart followed by a silent listen period.
            send_request(CMD_RESTART, 29'($urandom), 1'($urandom), 1'b0, '0);
            n = $urandom_range(1, 8);
            repeat (n) send_request(CMD_TICK, 29'($urandom), 1'($urandom), 1'b0, '0);
            counted += n + 1;
         end else if (pick < 88) begin
            send_request(CMD_NEXT, 29'($urandom), 1'($urandom), 1'b0, '0);
            counted++;
         end else if (pick < 95) begin
            // Pause, a few frames that are ignored, resume.
            send_request(CMD_PAUSE, 29'($urandom), 1'($urandom), 1'b0, '0);
            n = $urandom_range(1, 3);
            repeat (n) begin
               pick_frame(id, ext);
               send_request(CMD_FRAME, id, ext, 1'b0, '0);
            end
            send_request(CMD_PAUSE, 29'($urandom), 1'($urandom), 1'b0, '0);
            counted += 2;
         end else begin
            send_request(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), 29'($urandom),
                         1'($urandom), 1'b0, '0);
         end
      end
   endtask

   // Main sequence.
   initial begin
      script_row_type script [25];
      logic [15:0]    phase_listen [PHASES];
      int             i;

      phase_listen = '{16'd1500, 16'd1, 16'd0, 16'hFFFF, 16'd3, 16'd2, 16'd1};
      edge_ids = '{{1'b0, 29'h000}, {1'b0, 29'h07f}, {1'b0, 29'h080}, {1'b0, 29'h5ff},
                   {1'b0, 29'h600}, {1'b0, 29'h6ff}, {1'b0, 29'h700}, {1'b0, 29'h77f},
                   {1'b0, 29'h780}, {1'b0, 29'h7ff}, {1'b1, 29'h18efffff},
                   {1'b1, 29'h18f00000}, {1'b1, 29'h1cffffff}, {1'b1, 29'h1d000000},
                   {1'b1, 29'h1fffffff}, {1'b1, 29'h0}};

      // Directed script; typed rows hold statuses that follow from reset directly.
      script[0]  = '{CMD_TICK, 29'h0, 1'b0, 1'b1,
                     make_status(0, 1, 0, 0, PROTO_RAW, 0, NO_SLOT, 0, 0, 0)};
      script[1]  = '{CMD_SPARE_LO, 29'h1fffffff, 1'b1, 1'b1,
                     make_status(0, 1, 0, 0, PROTO_RAW, 0, NO_SLOT, 0, 0, 0)};
      script[2]  = '{CMD_SPARE_HI, 29'h0, 1'b0, 1'b1,
                     make_status(0, 1, 0, 0, PROTO_RAW, 0, NO_SLOT, 0, 0, 0)};
      script[3]  = '{CMD_PAUSE, 29'h0, 1'b0, 1'b1,
                     make_status(0, 1, 1, 0, PROTO_RAW, 0, NO_SLOT, 0, 0, 0)};
      script[4]  = '{CMD_FRAME, 29'h123, 1'b0, 1'b1,
                     make_status(0, 1, 1, 0, PROTO_RAW, 0, NO_SLOT, 0, 0, 0)};
      script[5]  = '{CMD_PAUSE, 29'h0, 1'b0, 1'b1,
                     make_status(0, 1, 0, 0, PROTO_RAW, 0, NO_SLOT, 0, 0, 0)};
      script[6]  = '{CMD_FRAME, 29'h000, 1'b0, 1'b1,
                     make_status(0, 1, 0, 0, PROTO_CANOPEN, 1, 0, 1, 0, 1)};
      script[7]  = '{CMD_FRAME, 29'h7ff, 1'b0, 1'b0, '0};
      script[8]  = '{CMD_FRAME, 29'h1fffffff, 1'b1, 1'b0, '0};
      script[9]  = '{CMD_FRAME, 29'h18f00000, 1'b1, 1'b0, '0};
      script[10] = '{CMD_FRAME, 29'h1cffffff, 1'b1, 1'b0, '0};
      script[11] = '{CMD_FRAME, 29'h18efffff, 1'b1, 1'b0, '0};
      script[12] = '{CMD_FRAME, 29'h000, 1'b1, 1'b0, '0};
      script[13] = '{CMD_FRAME, 29'h000, 1'b0, 1'b0, '0};
      script[14] = '{CMD_TICK, 29'h0, 1'b0, 1'b0, '0};
      script[15] = '{CMD_NEXT, 29'h0, 1'b0, 1'b1,
                     make_status(1, 0, 0, 1, PROTO_RAW, 0, NO_SLOT, 0, 0, 0)};
      script[16] = '{CMD_FRAME, 29'h00000001, 1'b1, 1'b0, '0};
      script[17] = '{CMD_FRAME, 29'h080, 1'b0, 1'b0, '0};
      script[18] = '{CMD_FRAME, 29'h5ff, 1'b0, 1'b0, '0};
      script[19] = '{CMD_FRAME, 29'h700, 1'b0, 1'b0, '0};
      script[20] = '{CMD_FRAME, 29'h77f, 1'b0, 1'b0, '0};
      script[21] = '{CMD_FRAME, 29'h780, 1'b0, 1'b0, '0};
      script[22] = '{CMD_TICK, 29'h0, 1'b0, 1'b0, '0};
      script[23] = '{CMD_RESTART, 29'h0, 1'b0, 1'b1,
                     make_status(0, 1, 0, 1, PROTO_RAW, 0, NO_SLOT, 0, 0, 0)};
      script[24] = '{CMD_TICK, 29'h0, 1'b0, 1'b0, '0};

      // Model and block both start from reset.
      listen_limit = LISTEN_RESET;
      clear_capture();
      rate_q   = '0;
      auto_q   = 1'b1;
      paused_q = 1'b0;
      listen_q = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         send_request(script[i].cmd, script[i].id, script[i].ext, script[i].typed,
                      script[i].want);
      end

      // One phase per listen period; the first keeps the reset value.
      for (i = 0; i < PHASES; i++) begin
         if (i != 0) write_listen(phase_listen[i]);
         refill_pool();
         run_traffic(PHASE_REQ / 2);
         if (i == 1) hold_off_request = 1'b1;
         if (i == 2) drain_status();
         run_traffic(PHASE_REQ / 2);
      end

      drain_status();
      repeat (DRAIN_CYC * 2) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
